// ===== hw/rtl/ssf_pkg.sv =====
// ----------------------------------------------------------------------------
// ssf_pkg: shared types and constants of the substring finder
// Register map indexes, cell control bundle and the ASCII fold helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssf_pkg;

  localparam int NEEDLE_BYTES = 16;
  localparam int NEEDLE_W     = 8 * NEEDLE_BYTES;
  localparam int LEN_W        = 5;
  localparam int REG_IDX_W    = 3;

  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FOLD_CASE      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SEARCH_START   = 3'd4;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  typedef struct packed {
    logic                shift;
    logic                fold;
    logic [LEN_W-1:0]    len;
    logic [NEEDLE_W-1:0] needle;
  } cell_ctrl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
      r = c + (CHAR_LOWER_A - CHAR_UPPER_A);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/streaming_substring_finder_top.sv =====
// ----------------------------------------------------------------------------
// streaming_substring_finder_top: streaming needle search over a byte stream
// Shifts text bytes through a row of compare cells and reports the first
// match at or after the start position when the last byte of a run arrives.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the input stalls only while a last byte waits
//   in stage one behind a result item that is not taken.
// Results: a last byte is registered in stage one, and its result item moves into
//   the result register once that is free. Reset: configuration registers and
//   stream state clear at once; the window needs no clearing since only bytes of the current run are ever compared.
`timescale 1ns / 1ps
`default_nettype none

module streaming_substring_finder_top
  import ssf_pkg::*;
#(
  parameter int MAX_PATTERN = 16,
  parameter int COUNT_BITS  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
  input  wire logic        s_tlast,   // final_byte
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [31:0] hit_position, [63:32] text_length
  output logic             m_tuser,   // hit
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam int WIDE = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // configuration registers
  logic [63:0]      pat_lo_q, pat_hi_q;
  logic [LEN_W-1:0] pat_len_q;
  logic             fold_q;
  logic [31:0]      start_q;
  logic             cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= '0;
      fold_q    <= 1'b0;
      start_q   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PATTERN_LOW:    pat_lo_q  <= pwdata;
        REG_PATTERN_HIGH:   pat_hi_q  <= pwdata;
        REG_PATTERN_LENGTH: pat_len_q <= pwdata[LEN_W-1:0];
        REG_FOLD_CASE:      fold_q    <= pwdata[0];
        REG_SEARCH_START:   start_q   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PATTERN_LOW:    prdata = pat_lo_q;
      REG_PATTERN_HIGH:   prdata = pat_hi_q;
      REG_PATTERN_LENGTH: prdata = {{(64-LEN_W){1'b0}}, pat_len_q};
      REG_FOLD_CASE:      prdata = {63'd0, fold_q};
      REG_SEARCH_START:   prdata = {32'd0, start_q};
      default:            prdata = '0;
    endcase
  end

  // handshake and pipeline control
  logic s_fire, s1_adv, out_free;
  logic s1_valid_q, s1_last_q, s1_counted_q;
  logic [COUNT_BITS-1:0] s1_cnt_q;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic counted;

  assign out_free = !m_tvalid || m_tready;
  assign s1_adv   = s1_valid_q && (!s1_last_q || out_free);
  assign s_tready = !s1_valid_q || !s1_last_q || out_free;
  assign s_fire   = s_tvalid && s_tready;

  assign counted = count_q != CNT_MAX;

  always_comb begin
    count_d = count_q;
    if (s_fire) begin
      if (s_tlast) begin
        count_d = '0;
      end else if (counted) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (s_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_last_q    <= s_tlast;
      s1_counted_q <= counted;
      s1_cnt_q     <= counted ? count_q + 1'b1 : count_q;
    end
  end

  // cell row
  cell_ctrl_t ctrl;
  logic [7:0] chain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] cell_ok;

  assign ctrl.shift  = s_fire;
  assign ctrl.fold   = fold_q;
  assign ctrl.len    = pat_len_q;
  assign ctrl.needle = {pat_hi_q, pat_lo_q};
  assign chain[0]    = s_tdata;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    ssf_cell #(.IDX(j)) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .data_i (chain[j]),
      .data_o (chain[j+1]),
      .ok_o   (cell_ok[j])
    );
  end

  // match decision on the window of the item in stage one
  logic [WIDE-1:0] cnt_w, len_w, srch_w, begin_w;
  logic            len_fits, match_now;
  logic            match_seen_q;
  logic [WIDE-1:0] first_q;

  assign cnt_w    = WIDE'(s1_cnt_q);
  assign len_w    = WIDE'(pat_len_q);
  assign srch_w   = WIDE'(start_q);
  assign begin_w  = cnt_w - len_w;
  assign len_fits = ({2'b00, pat_len_q} <= 7'(MAX_PATTERN));

  assign match_now = s1_counted_q && !match_seen_q && (pat_len_q != '0) && len_fits &&
                     (cnt_w >= len_w) && (begin_w >= srch_w) && (&cell_ok);

  logic            res_hit;
  logic [WIDE-1:0] res_pos;

  always_comb begin
    res_hit = match_seen_q || match_now;
    res_pos = match_now ? begin_w : first_q;
    if (pat_len_q == '0) begin
      res_hit = srch_w <= cnt_w;
      res_pos = srch_w;
    end
    if (!res_hit) begin
      res_pos = cnt_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_seen_q <= 1'b0;
      first_q      <= '0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        match_seen_q <= 1'b0;
        first_q      <= '0;
      end else if (match_now) begin
        match_seen_q <= 1'b1;
        first_q      <= begin_w;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      m_tuser <= res_hit;
      m_tdata <= {cnt_w[31:0], res_pos[31:0]};
    end
  end

  // checks
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !m_tready && s1_valid_q && s1_last_q) |-> !s_tready)
    else $error("stage one would overwrite a pending result");

  a_clear_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> !match_seen_q)
    else $error("match state not cleared after a run");

  a_count_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_tlast) |=> (count_q == '0))
    else $error("byte count not restarted after a run");

  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !m_tuser) |-> (m_tdata[31:0] == m_tdata[63:32]))
    else $error("miss result position differs from length");

endmodule

`default_nettype wire

// ===== hw/rtl/ssf_cell.sv =====
// ----------------------------------------------------------------------------
// ssf_cell: one window cell
// Holds one recent byte, passes it on to the next cell on each item and
// compares it against the needle byte that lines up with its position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssf_cell
  import ssf_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic       clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic [7:0] data_i,
  output logic      [7:0] data_o,
  output logic            ok_o
);

  localparam logic [6:0] IDX7 = 7'(IDX);

  logic [7:0] win_q, win_d;
  logic [6:0] len7;
  logic [6:0] sel;
  logic       used;
  logic [7:0] nb;

  assign win_d = ctrl_i.shift ? data_i : win_q;

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // needle byte len-1-IDX aligns with this cell; bytes at index 16 and up read as zero
  assign len7 = {2'b00, ctrl_i.len};
  assign used = len7 > IDX7;
  assign sel  = len7 - IDX7 - 7'd1;
  assign nb   = (sel < 7'(NEEDLE_BYTES)) ? ctrl_i.needle[{sel[3:0], 3'b000} +: 8] : 8'h00;

  assign ok_o   = !used || (fold_byte(win_q, ctrl_i.fold) == fold_byte(nb, ctrl_i.fold));
  assign data_o = win_q;

endmodule

`default_nettype wire

// ===== sim/substring_result_checker.sv =====
// ----------------------------------------------------------------------------
// substring_result_checker: scoreboard for the streaming substring finder
// Mirrors register writes seen on the APB port, rebuilds each search from the
// accepted text items and compares every result item field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module substring_result_checker
  import ssf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // [7:0] text_byte
  input  logic        s_tlast_i,   // final_byte
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [63:0] m_tdata_i,   // [31:0] hit_position, [63:32] text_length
  input  logic        m_tuser_i,   // hit
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [5:0]  paddr_i,
  input  logic [63:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int          WINDOW       = 16;
  localparam logic [31:0] COUNT_MAX    = '1;
  localparam int          REPORT_LIMIT = 10;

  typedef struct packed {
    logic        hit;
    logic [31:0] position;
    logic [31:0] length;
  } search_report_t;

  logic [63:0] needle_lo;
  logic [63:0] needle_hi;
  logic [4:0]  needle_len;
  logic        fold_en;
  logic [31:0] match_floor;

  logic [7:0]  window [WINDOW];
  logic [31:0] seen;
  logic        found;
  logic [31:0] found_at;

  search_report_t expected_reports[$];
  int             fault_total;

  function automatic logic [7:0] lower_if_folding(input logic [7:0] c);
    if (fold_en && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
      return c + (CHAR_LOWER_A - CHAR_UPPER_A);
    end
    return c;
  endfunction

  task automatic clear_text_state();
    for (int k = 0; k < WINDOW; k++) window[k] = 8'h00;
    seen     = '0;
    found    = 1'b0;
    found_at = '0;
  endtask

  task automatic absorb_text_byte(input logic [7:0] b, input logic last);
    logic [127:0]   needle;
    logic [31:0]    first;
    logic           same;
    logic           counted;
    search_report_t rpt;
    needle = {needle_hi, needle_lo};
    for (int k = WINDOW - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = b;
    counted = (seen != COUNT_MAX);
    if (counted) seen = seen + 32'd1;
    if (counted && !found && needle_len >= 5'd1 && needle_len <= 5'(WINDOW) &&
        seen >= 32'(needle_len)) begin
      first = seen - 32'(needle_len);
      if (first >= match_floor) begin
        same = 1'b1;
        for (int i = 0; i < int'(needle_len); i++) begin
          if (lower_if_folding(window[int'(needle_len) - 1 - i]) !=
              lower_if_folding(needle[8*i +: 8])) begin
            same = 1'b0;
          end
        end
        if (same) begin
          found    = 1'b1;
          found_at = first;
        end
      end
    end
    if (last) begin
      rpt.hit      = found;
      rpt.position = found_at;
      // empty needle: matches at the start position when it is not past the end of the text
      if (needle_len == 5'd0) begin
        rpt.hit      = (match_floor <= seen);
        rpt.position = match_floor;
      end
      if (!rpt.hit) rpt.position = seen;
      rpt.length = seen;
      expected_reports.push_back(rpt);
      clear_text_state();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    search_report_t want;
    if (!rst_ni) begin
      needle_lo   = '0;
      needle_hi   = '0;
      needle_len  = '0;
      fold_en     = 1'b0;
      match_floor = '0;
      clear_text_state();
      expected_reports.delete();
      fault_total = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[5:3])
          REG_PATTERN_LOW:    needle_lo   = pwdata_i;
          REG_PATTERN_HIGH:   needle_hi   = pwdata_i;
          REG_PATTERN_LENGTH: needle_len  = pwdata_i[4:0];
          REG_FOLD_CASE:      fold_en     = pwdata_i[0];
          REG_SEARCH_START:   match_floor = pwdata_i[31:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_reports.size() == 0) begin
          if (fault_total < REPORT_LIMIT) begin
            $display("unexpected result item: hit=%0d pos=%0d len=%0d",
                     m_tuser_i, m_tdata_i[31:0], m_tdata_i[63:32]);
          end
          fault_total++;
        end else begin
          want = expected_reports.pop_front();
          if (want.hit != m_tuser_i || want.position != m_tdata_i[31:0] ||
              want.length != m_tdata_i[63:32]) begin
            if (fault_total < REPORT_LIMIT) begin
              $display("mismatch: exp hit=%0d pos=%0d len=%0d got hit=%0d pos=%0d len=%0d",
                       want.hit, want.position, want.length,
                       m_tuser_i, m_tdata_i[31:0], m_tdata_i[63:32]);
            end
            fault_total++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) absorb_text_byte(s_tdata_i, s_tlast_i);
      fail_count_o <= fault_total;
      pending_o    <= expected_reports.size();
    end
  end

endmodule

// ===== sim/streaming_substring_finder_top_tb.sv =====
// ----------------------------------------------------------------------------
// streaming_substring_finder_top_tb: stimulus and verdict for the finder
// Drives short directed searches, then random phases of needles and texts
// with random idling on both streams and one long result-side hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module streaming_substring_finder_top_tb;
  import ssf_pkg::*;

  localparam int              RANDOM_ITEMS   = 1350;
  localparam int              WATCHDOG_LIMIT = 3000;
  localparam int              HOLD_CYCLES    = 400;
  localparam int              SETTLE_CYCLES  = 4;
  localparam logic [2:0]      REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0]      REG_SPARE_LAST  = 3'd7;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [5:0]  paddr    = '0;
  logic [63:0] pwdata   = '0;

  logic        s_tready;
  logic        m_tvalid;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic [63:0] prdata;
  logic        pready;

  int          fail_count;
  int          result_pending;

  int          items_sent  = 0;
  int          quiet_cycles = 0;
  bit          tx_idle_en  = 1'b0;
  bit          rx_idle_en  = 1'b0;
  bit          hold_req    = 1'b0;

  logic [7:0]  needle [16];
  int          needle_len;
  bit          fold_on;
  logic [31:0] start_at;

  streaming_substring_finder_top uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  substring_result_checker result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (result_pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(1, 2);
    if (r < 18) return $urandom_range(3, 6);
    return $urandom_range(15, 50);
  endfunction

  function automatic logic [7:0] random_letter();
    if ($urandom_range(0, 1) == 0) return CHAR_UPPER_A + 8'($urandom_range(0, 25));
    return CHAR_LOWER_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c, input int pct);
    bit letter;
    letter = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_A + 8'd25);
    if (letter && $urandom_range(0, 99) < pct) return c ^ 8'h20;
    return c;
  endfunction

  function automatic int pick_text_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 24);
    if (r < 95) return $urandom_range(25, 60);
    return $urandom_range(100, 250);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic last);
    if (tx_idle_en && $urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      repeat (pick_idle()) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input logic [7:0] text[$]);
    for (int i = 0; i < text.size(); i++) send_item(text[i], i == text.size() - 1);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (result_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure();
    logic [63:0] lo;
    logic [63:0] hi;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = needle[i];
      hi[8*i +: 8] = needle[8+i];
    end
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, 64'(needle_len));
    write_reg(REG_FOLD_CASE, 64'(fold_on));
    write_reg(REG_SEARCH_START, 64'(start_at));
  endtask

  task automatic send_haystack(input int n, input bit plant);
    logic [7:0] text[$];
    int         p;
    int         r;
    int         span;
    span = (needle_len >= 1 && needle_len <= 16) ? needle_len : 16;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 4) text.push_back(flip_case(needle[$urandom_range(0, span - 1)], 30));
      else if (r < 7) text.push_back(8'($urandom_range(0, 255)));
      else text.push_back(flip_case(CHAR_LOWER_A + 8'($urandom_range(0, 3)), 50));
    end
    if (plant && needle_len >= 1 && needle_len <= 16 && n >= needle_len) begin
      p = $urandom_range(0, n - needle_len);
      for (int i = 0; i < needle_len; i++) begin
        text[p+i] = flip_case(needle[i], fold_on ? 50 : 10);
      end
    end
    send_text(text);
  endtask

  task automatic pick_needle(input bit letters);
    for (int i = 0; i < 16; i++) begin
      needle[i] = (letters || $urandom_range(0, 1) == 0) ? random_letter()
                                                        : 8'($urandom_range(0, 255));
    end
  endtask

  task automatic setup_phase(input int phase);
    int r;
    rx_idle_en = ($urandom_range(0, 3) != 0);
    tx_idle_en = ($urandom_range(0, 3) != 0);
    fold_on    = 1'($urandom_range(0, 1));
    start_at   = '0;
    case (phase)
      0: begin
        for (int i = 0; i < 16; i++) needle[i] = 8'hFF;
        needle_len = 16;
        fold_on    = 1'b0;
      end
      1: begin
        for (int i = 0; i < 16; i++) needle[i] = 8'h00;
        needle_len = 1;
        fold_on    = 1'b1;
      end
      2: begin
        pick_needle(1'b1);
        needle_len = 0;
        start_at   = 32'($urandom_range(0, 30));
      end
      3: begin
        pick_needle(1'b1);
        needle_len = 2;
        fold_on    = 1'b1;
      end
      4: begin
        pick_needle(1'b0);
        needle_len = 3;
        start_at   = '1;
      end
      5: begin
        pick_needle(1'b0);
        needle_len = 31;
      end
      default: begin
        pick_needle(1'($urandom_range(0, 1)));
        r = $urandom_range(0, 9);
        if (r == 0) needle_len = 0;
        else if (r == 1) needle_len = 16;
        else if (r < 7) needle_len = $urandom_range(1, 4);
        else needle_len = $urandom_range(5, 16);
        r = $urandom_range(0, 19);
        if (r < 9) start_at = '0;
        else if (r < 16) start_at = 32'($urandom_range(0, 20));
        else if (r < 18) start_at = 32'($urandom_range(50, 200));
        else if (r < 19) start_at = '1;
        else start_at = $urandom;
      end
    endcase
  endtask

  // result side: random stalls, and one long hold when asked
  initial begin : receiver
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        m_tready <= 1'b1;
        @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (pick_idle()) @(posedge clk);
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase;
    int phase_end;
    int target;
    for (int i = 0; i < 16; i++) needle[i] = 8'h00;
    needle_len = 0;
    fold_on    = 1'b0;
    start_at   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty needle at reset settings
    send_text('{8'h00});
    settle();
    // empty needle with start beyond the text
    start_at = 32'd5;
    configure();
    send_text('{8'hFF, 8'h7F, 8'h80});
    settle();
    // writes outside the register map are ignored
    write_reg(REG_SPARE_FIRST, {$urandom, $urandom});
    write_reg(REG_SPARE_LAST, {$urandom, $urandom});
    send_text('{8'h41});
    settle();
    // needle "aBc", case folded
    needle[0]  = 8'h61;
    needle[1]  = 8'h42;
    needle[2]  = 8'h63;
    needle_len = 3;
    fold_on    = 1'b1;
    start_at   = '0;
    configure();
    send_text('{8'h78, 8'h41, 8'h62, 8'h43});
    settle();
    fold_on = 1'b0;
    configure();
    send_text('{8'h78, 8'h41, 8'h62, 8'h43, 8'h61, 8'h42, 8'h63});
    settle();
    // match before the start position is skipped
    fold_on  = 1'b1;
    start_at = 32'd2;
    configure();
    send_text('{8'h61, 8'h42, 8'h63, 8'h61, 8'h42, 8'h63});
    settle();
    // needle longer than the window never matches
    needle_len = 31;
    configure();
    send_text('{8'h61});

    target = items_sent + RANDOM_ITEMS;
    phase  = 0;
    while (items_sent < target) begin
      settle();
      setup_phase(phase);
      configure();
      if (phase == 3) begin
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        for (int k = 0; k < 40; k++) send_haystack($urandom_range(1, 2), 1'b1);
      end else begin
        phase_end = items_sent + $urandom_range(60, 140);
        while (items_sent < phase_end && items_sent < target) begin
          send_haystack(pick_text_length(), $urandom_range(0, 9) < 7);
        end
      end
      phase++;
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (result_pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (fail_count == 0 && result_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
